>>> sv/scm_pkg.sv
// shared types, constants and arithmetic helpers for the scalar colormap
package scm_pkg;

   localparam int FRACTION_BITS = 15;
   localparam int MAX_LEVELS    = 256;
   localparam int ONE_Q         = 1 << FRACTION_BITS;
   localparam int HALF_Q        = 1 << (FRACTION_BITS - 1);

   localparam int VAL_W   = 16;
   localparam int LEVEL_W = 9;

   localparam int DIV_D_W             = 18;
   localparam int DIV_Q_W             = 16;
   localparam int DIV_N_W             = DIV_D_W + DIV_Q_W;
   localparam int DIV_BITS_PER_STAGE  = 2;
   localparam int DIV_STAGES          = DIV_Q_W / DIV_BITS_PER_STAGE;

   localparam int PIPE_DEPTH = 9 + 2 * DIV_STAGES;

   localparam int RECIP_TEN   = 419431;
   localparam int RECIP_SHIFT = 22;

   typedef enum logic [2:0] {
      CSR_PALETTE = 3'd0,
      CSR_BAND    = 3'd1,
      CSR_LEVELS  = 3'd2,
      CSR_HUE     = 3'd3,
      CSR_SAT     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PAL_GREY    = 2'd0,
      PAL_RAINBOW = 2'd1,
      PAL_BIPOLAR = 2'd2,
      PAL_ZEBRA   = 2'd3
   } palette_type;

   typedef enum logic [1:0] {
      MAX_RED   = 2'd0,
      MAX_GREEN = 2'd1,
      MAX_BLUE  = 2'd2
   } max_sel_type;

   typedef struct packed {
      logic [VAL_W-1:0] red;
      logic [VAL_W-1:0] green;
      logic [VAL_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [VAL_W-1:0] mx;
      rgb_type          rgb;
   } side_type;

   typedef struct packed {
      logic [DIV_D_W-1:0] rem;
      logic [DIV_Q_W-1:0] lo;
      logic [DIV_D_W-1:0] dvs;
      logic [DIV_Q_W-1:0] quo;
   } div_state_type;

   function automatic logic [VAL_W-1:0] qmul(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b);
      logic [2*VAL_W-1:0] p;
      p = 32'(a) * 32'(b) + 32'(HALF_Q);
      return p[FRACTION_BITS+VAL_W-1:FRACTION_BITS];
   endfunction

   function automatic div_state_type div_step(input div_state_type st);
      div_state_type r;
      logic [DIV_D_W:0] t;
      r = st;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         t = {r.rem, r.lo[DIV_Q_W-1]};
         r.lo = {r.lo[DIV_Q_W-2:0], 1'b0};
         if (t >= {1'b0, r.dvs}) begin
            t = t - {1'b0, r.dvs};
            r.quo = {r.quo[DIV_Q_W-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[DIV_Q_W-2:0], 1'b0};
         end
         r.rem = t[DIV_D_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> sv/scalar_colormap_hsv_adjust.sv
// top level: scalar to rgb colormap with banding and hsv adjustment
//
//   channel   ports                                        direction
//   req       req_valid req_stall req_scalar_in            request in
//   rsp       rsp_valid rsp_stall rsp_red/green/blue_out   result out
//   csr       csr_valid csr_ready csr_index csr_data       register write
//
// one request per cycle while req_stall is low; each result passes through the banding divider
// and then the saturation/hue dividers (8 stages each)
// synchronous active-high reset clears valid bits and sets configuration registers to defaults
// a stalled result moves into a skid register; req_stall rises only when it is full
module scalar_colormap_hsv_adjust (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_scalar_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_red_out,
   output logic [15:0] rsp_green_out,
   output logic [15:0] rsp_blue_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int DS = scm_pkg::DIV_STAGES;

   scm_pkg::palette_type          palette_ff;
   logic                          band_en_ff;
   logic [scm_pkg::LEVEL_W-1:0]   level_ff;
   logic [15:0]                   hue_shift_ff, sat_gain_ff;

   logic [scm_pkg::LEVEL_W-1:0]   lv;
   logic [7:0]                    lv_m1;
   logic [15:0]                   hs, sg;
   logic                          bypass;
   logic                          en;

   logic [scm_pkg::PIPE_DEPTH-1:0] pipe_valid_ff;

   logic [15:0]                   in_v_ff;
   logic [23:0]                   band_prod;
   logic [7:0]                    band_k;
   logic [scm_pkg::DIV_N_W-1:0]   band_dvd_in, band_dvd_ff;
   logic [scm_pkg::DIV_D_W-1:0]   band_dvs_in, band_dvs_ff;
   logic [15:0]                   band_quo;
   scm_pkg::rgb_type              pal_rgb;

   scm_pkg::rgb_type              h1_rgb_ff;
   logic [15:0]                   h1_mx_in, h1_mn_in, h1_mx_ff, h1_d_ff;
   scm_pkg::max_sel_type          h1_sel_in, h1_sel_ff;

   logic signed [18:0]            hn, hn_wrap;
   logic [17:0]                   d6, d3, n2;
   logic [scm_pkg::DIV_N_W-1:0]   hue_dvd_in, hue_dvd_ff, sat_dvd_in, sat_dvd_ff;
   logic [scm_pkg::DIV_D_W-1:0]   hue_dvs_in, hue_dvs_ff, sat_dvs_in, sat_dvs_ff;
   scm_pkg::side_type             h2_side_ff;
   scm_pkg::side_type             side_ff [DS];
   logic [15:0]                   hue_quo, sat_quo;
   scm_pkg::rgb_type              final_rgb;

   logic                          arrive;
   logic                          out_ready;
   logic                          rsp_valid_ff, skid_valid_ff;
   scm_pkg::rgb_type              rsp_rgb_ff, skid_rgb_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff   <= scm_pkg::PAL_RAINBOW;
         band_en_ff   <= 1'b0;
         level_ff     <= 9'(scm_pkg::MAX_LEVELS);
         hue_shift_ff <= 16'(scm_pkg::ONE_Q);
         sat_gain_ff  <= 16'(scm_pkg::ONE_Q);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            scm_pkg::CSR_PALETTE: palette_ff   <= scm_pkg::palette_type'(csr_data[1:0]);
            scm_pkg::CSR_BAND:    band_en_ff   <= csr_data[0];
            scm_pkg::CSR_LEVELS:  level_ff     <= csr_data[8:0];
            scm_pkg::CSR_HUE:     hue_shift_ff <= csr_data;
            scm_pkg::CSR_SAT:     sat_gain_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (level_ff < 9'd2) begin
         lv = 9'd2;
      end else if (level_ff > 9'(scm_pkg::MAX_LEVELS)) begin
         lv = 9'(scm_pkg::MAX_LEVELS);
      end else begin
         lv = level_ff;
      end
      lv_m1  = 8'(lv - 9'd1);
      hs     = (hue_shift_ff > 16'(scm_pkg::ONE_Q)) ? 16'(scm_pkg::ONE_Q) : hue_shift_ff;
      sg     = (sat_gain_ff > 16'(scm_pkg::ONE_Q)) ? 16'(scm_pkg::ONE_Q) : sat_gain_ff;
      bypass = (hs == 16'(scm_pkg::ONE_Q)) && (sg == 16'(scm_pkg::ONE_Q));
   end

   // pipeline control
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
      end else if (en) begin
         pipe_valid_ff <= {pipe_valid_ff[scm_pkg::PIPE_DEPTH-2:0], req_valid};
      end
   end

   // input saturation and band quantizer setup
   always_ff @(posedge clock) begin
      if (en) begin
         in_v_ff <= (req_scalar_in > 16'(scm_pkg::ONE_Q)) ? 16'(scm_pkg::ONE_Q)
                                                          : req_scalar_in;
      end
   end

   always_comb begin
      band_prod = 24'(in_v_ff) * 24'(lv_m1) + 24'(scm_pkg::HALF_Q);
      band_k    = band_prod[22:15];
      if (band_en_ff) begin
         band_dvd_in = scm_pkg::DIV_N_W'({band_k, 15'b0}) + scm_pkg::DIV_N_W'(lv_m1[7:1]);
         band_dvs_in = scm_pkg::DIV_D_W'(lv_m1);
      end else begin
         band_dvd_in = scm_pkg::DIV_N_W'(in_v_ff);
         band_dvs_in = scm_pkg::DIV_D_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         band_dvd_ff <= band_dvd_in;
         band_dvs_ff <= band_dvs_in;
      end
   end

   scm_div u_band_div (
      .clock    (clock),
      .en       (en),
      .dividend (band_dvd_ff),
      .divisor  (band_dvs_ff),
      .quotient (band_quo)
   );

   scm_palette u_palette (
      .clock          (clock),
      .en             (en),
      .value          (band_quo),
      .palette_select (palette_ff),
      .levels         (lv),
      .rgb            (pal_rgb)
   );

   // max, min and difference
   always_comb begin
      h1_mx_in  = pal_rgb.red;
      h1_mn_in  = pal_rgb.red;
      if (pal_rgb.green > h1_mx_in) h1_mx_in = pal_rgb.green;
      if (pal_rgb.blue > h1_mx_in)  h1_mx_in = pal_rgb.blue;
      if (pal_rgb.green < h1_mn_in) h1_mn_in = pal_rgb.green;
      if (pal_rgb.blue < h1_mn_in)  h1_mn_in = pal_rgb.blue;
      if (pal_rgb.red == h1_mx_in) begin
         h1_sel_in = scm_pkg::MAX_RED;
      end else if (pal_rgb.green == h1_mx_in) begin
         h1_sel_in = scm_pkg::MAX_GREEN;
      end else begin
         h1_sel_in = scm_pkg::MAX_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h1_rgb_ff <= pal_rgb;
         h1_mx_ff  <= h1_mx_in;
         h1_d_ff   <= h1_mx_in - h1_mn_in;
         h1_sel_ff <= h1_sel_in;
      end
   end

   // hue and saturation dividends
   always_comb begin
      d6 = {h1_d_ff, 2'b0} + {1'b0, h1_d_ff, 1'b0};
      d3 = {1'b0, h1_d_ff, 1'b0} + 18'(h1_d_ff);
      case (h1_sel_ff)
         scm_pkg::MAX_RED:
            hn = signed'({3'b0, h1_rgb_ff.green}) - signed'({3'b0, h1_rgb_ff.blue});
         scm_pkg::MAX_GREEN:
            hn = signed'({2'b0, h1_d_ff, 1'b0}) + signed'({3'b0, h1_rgb_ff.blue})
                 - signed'({3'b0, h1_rgb_ff.red});
         default:
            hn = signed'({1'b0, h1_d_ff, 2'b0}) + signed'({3'b0, h1_rgb_ff.red})
                 - signed'({3'b0, h1_rgb_ff.green});
      endcase
      hn_wrap    = hn + signed'({1'b0, d6});
      n2         = (hn < 0) ? hn_wrap[17:0] : hn[17:0];
      hue_dvd_in = scm_pkg::DIV_N_W'({n2, 15'b0}) + scm_pkg::DIV_N_W'(d3);
      hue_dvs_in = (h1_d_ff == '0) ? scm_pkg::DIV_D_W'(1) : d6;
      sat_dvd_in = scm_pkg::DIV_N_W'({h1_d_ff, 15'b0}) + scm_pkg::DIV_N_W'(h1_mx_ff[15:1]);
      sat_dvs_in = (h1_mx_ff == '0) ? scm_pkg::DIV_D_W'(1) : scm_pkg::DIV_D_W'(h1_mx_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_dvd_ff     <= hue_dvd_in;
         hue_dvs_ff     <= hue_dvs_in;
         sat_dvd_ff     <= sat_dvd_in;
         sat_dvs_ff     <= sat_dvs_in;
         h2_side_ff.mx  <= h1_mx_ff;
         h2_side_ff.rgb <= h1_rgb_ff;
         side_ff[0]     <= h2_side_ff;
         for (int s = 1; s < DS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   scm_div u_hue_div (
      .clock    (clock),
      .en       (en),
      .dividend (hue_dvd_ff),
      .divisor  (hue_dvs_ff),
      .quotient (hue_quo)
   );

   scm_div u_sat_div (
      .clock    (clock),
      .en       (en),
      .dividend (sat_dvd_ff),
      .divisor  (sat_dvs_ff),
      .quotient (sat_quo)
   );

   scm_hsv_to_rgb u_hsv_to_rgb (
      .clock     (clock),
      .en        (en),
      .hue       (hue_quo),
      .sat       (sat_quo),
      .side      (side_ff[DS-1]),
      .hue_shift (hs),
      .sat_gain  (sg),
      .bypass    (bypass),
      .rgb       (final_rgb)
   );

   // output register with skid
   assign arrive    = pipe_valid_ff[scm_pkg::PIPE_DEPTH-1] && en;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_ready) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (arrive) begin
         if (out_ready) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_ready) begin
            rsp_rgb_ff <= skid_rgb_ff;
         end
      end else if (arrive) begin
         if (out_ready) begin
            rsp_rgb_ff <= final_rgb;
         end else begin
            skid_rgb_ff <= final_rgb;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_rgb_ff.red;
   assign rsp_green_out = rsp_rgb_ff.green;
   assign rsp_blue_out  = rsp_rgb_ff.blue;

endmodule

>>> sv/scm_div.sv
// pipelined restoring divider, two quotient bits per stage
module scm_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [scm_pkg::DIV_N_W-1:0]   dividend,
   input  logic [scm_pkg::DIV_D_W-1:0]   divisor,
   output logic [scm_pkg::DIV_Q_W-1:0]   quotient
);

   scm_pkg::div_state_type start;
   scm_pkg::div_state_type st_in [scm_pkg::DIV_STAGES];
   scm_pkg::div_state_type st_ff [scm_pkg::DIV_STAGES];

   always_comb begin
      start.rem = dividend[scm_pkg::DIV_N_W-1:scm_pkg::DIV_Q_W];
      start.lo  = dividend[scm_pkg::DIV_Q_W-1:0];
      start.dvs = divisor;
      start.quo = '0;
      st_in[0] = scm_pkg::div_step(start);
      for (int s = 1; s < scm_pkg::DIV_STAGES; s++) begin
         st_in[s] = scm_pkg::div_step(st_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign quotient = st_ff[scm_pkg::DIV_STAGES-1].quo;

endmodule

>>> sv/scm_palette.sv
// two-stage palette lookup: grey, rainbow, bipolar and zebra
module scm_palette (
   input  logic                          clock,
   input  logic                          en,
   input  logic [scm_pkg::VAL_W-1:0]     value,
   input  scm_pkg::palette_type          palette_select,
   input  logic [scm_pkg::LEVEL_W-1:0]   levels,
   output scm_pkg::rgb_type              rgb
);

   function automatic logic [19:0] rb_chan(input logic [19:0] x5, input int c,
                                           input int a, input int b);
      logic signed [22:0] sx;
      logic signed [22:0] da;
      logic signed [22:0] db;
      logic signed [22:0] t;
      sx = signed'(23'(x5));
      da = sx - signed'(23'(a * scm_pkg::ONE_Q));
      db = sx - signed'(23'(b * scm_pkg::ONE_Q));
      if (da < 0) begin
         da = -da;
      end
      if (db < 0) begin
         db = -db;
      end
      t = signed'(23'(c * scm_pkg::ONE_Q)) - da - db;
      if (t < 0) begin
         t = '0;
      end
      return t[19:0];
   endfunction

   function automatic logic [15:0] div10(input logic [19:0] t);
      logic [20:0] t5;
      logic [39:0] p;
      t5 = 21'(t) + 21'd5;
      p  = 40'(t5) * 40'(scm_pkg::RECIP_TEN);
      return p[scm_pkg::RECIP_SHIFT+15:scm_pkg::RECIP_SHIFT];
   endfunction

   logic [19:0]               x5;
   logic [24:0]               zprod;
   logic [9:0]                stripe;
   logic [19:0]               t_red_ff, t_green_ff, t_blue_ff;
   logic [scm_pkg::VAL_W-1:0] v_ff;
   logic                      zebra_ff, zebra_in;
   scm_pkg::rgb_type          rgb_ff, rgb_in;

   always_comb begin
      x5     = 20'(value) * 20'd22 + 20'(4 * scm_pkg::ONE_Q);
      zprod  = 25'(value) * 25'(levels);
      stripe = zprod[24:scm_pkg::FRACTION_BITS];
      if (stripe > 10'(levels - 9'd1)) begin
         stripe = 10'(levels - 9'd1);
      end
      zebra_in = stripe[0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_red_ff   <= rb_chan(x5, 15, 20, 25);
         t_green_ff <= rb_chan(x5, 20, 10, 20);
         t_blue_ff  <= rb_chan(x5, 15, 5, 10);
         v_ff       <= value;
         zebra_ff   <= zebra_in;
      end
   end

   always_comb begin
      case (palette_select)
         scm_pkg::PAL_GREY: begin
            rgb_in.red   = v_ff;
            rgb_in.green = v_ff;
            rgb_in.blue  = v_ff;
         end
         scm_pkg::PAL_RAINBOW: begin
            rgb_in.red   = div10(t_red_ff);
            rgb_in.green = div10(t_green_ff);
            rgb_in.blue  = div10(t_blue_ff);
         end
         scm_pkg::PAL_BIPOLAR: begin
            rgb_in.red   = v_ff;
            rgb_in.green = '0;
            rgb_in.blue  = 16'(scm_pkg::ONE_Q) - v_ff;
         end
         default: begin
            rgb_in.red   = zebra_ff ? 16'(scm_pkg::ONE_Q) : '0;
            rgb_in.green = rgb_in.red;
            rgb_in.blue  = rgb_in.red;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rgb_ff <= rgb_in;
      end
   end

   assign rgb = rgb_ff;

endmodule

>>> sv/scm_hsv_to_rgb.sv
// hue shift, saturation gain and three-stage hsv to rgb conversion
module scm_hsv_to_rgb (
   input  logic                          clock,
   input  logic                          en,
   input  logic [scm_pkg::VAL_W-1:0]     hue,
   input  logic [scm_pkg::VAL_W-1:0]     sat,
   input  scm_pkg::side_type             side,
   input  logic [scm_pkg::VAL_W-1:0]     hue_shift,
   input  logic [scm_pkg::VAL_W-1:0]     sat_gain,
   input  logic                          bypass,
   output scm_pkg::rgb_type              rgb
);

   localparam logic [scm_pkg::VAL_W-1:0] ONE16 = 16'(scm_pkg::ONE_Q);

   logic [16:0]               hue_adj;
   logic [17:0]               hue6;
   logic [2:0]                a1_sector_ff, a2_sector_ff, a3_sector_ff;
   logic [14:0]               a1_frac_ff;
   logic [scm_pkg::VAL_W-1:0] a1_sat_ff;
   scm_pkg::side_type         a1_side_ff, a2_side_ff, a3_side_ff;
   logic [scm_pkg::VAL_W-1:0] a2_pf_ff, a2_pnf_ff, a2_lx_ff, a3_lx_ff;
   logic [scm_pkg::VAL_W-1:0] a3_ly_ff, a3_lz_ff;

   always_comb begin
      if (hue < hue_shift) begin
         hue_adj = 17'(hue) + 17'(scm_pkg::ONE_Q) - 17'(hue_shift);
      end else begin
         hue_adj = 17'(hue) - 17'(hue_shift);
      end
      hue6 = {hue_adj[15:0], 2'b0} + {1'b0, hue_adj[15:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_sector_ff <= hue6[17:15];
         a1_frac_ff   <= hue6[14:0];
         a1_sat_ff    <= scm_pkg::qmul(sat, sat_gain);
         a1_side_ff   <= side;

         a2_pf_ff     <= scm_pkg::qmul(a1_sat_ff, {1'b0, a1_frac_ff});
         a2_pnf_ff    <= scm_pkg::qmul(a1_sat_ff, ONE16 - {1'b0, a1_frac_ff});
         a2_lx_ff     <= scm_pkg::qmul(a1_side_ff.mx, ONE16 - a1_sat_ff);
         a2_sector_ff <= a1_sector_ff;
         a2_side_ff   <= a1_side_ff;

         a3_ly_ff     <= scm_pkg::qmul(a2_side_ff.mx, ONE16 - a2_pf_ff);
         a3_lz_ff     <= scm_pkg::qmul(a2_side_ff.mx, ONE16 - a2_pnf_ff);
         a3_lx_ff     <= a2_lx_ff;
         a3_sector_ff <= a2_sector_ff;
         a3_side_ff   <= a2_side_ff;
      end
   end

   always_comb begin
      if (bypass) begin
         rgb = a3_side_ff.rgb;
      end else begin
         case (a3_sector_ff)
            3'd1: begin
               rgb.red = a3_ly_ff; rgb.green = a3_side_ff.mx; rgb.blue = a3_lx_ff;
            end
            3'd2: begin
               rgb.red = a3_lx_ff; rgb.green = a3_side_ff.mx; rgb.blue = a3_lz_ff;
            end
            3'd3: begin
               rgb.red = a3_lx_ff; rgb.green = a3_ly_ff; rgb.blue = a3_side_ff.mx;
            end
            3'd4: begin
               rgb.red = a3_lz_ff; rgb.green = a3_lx_ff; rgb.blue = a3_side_ff.mx;
            end
            3'd5: begin
               rgb.red = a3_side_ff.mx; rgb.green = a3_lx_ff; rgb.blue = a3_ly_ff;
            end
            default: begin
               rgb.red = a3_side_ff.mx; rgb.green = a3_lz_ff; rgb.blue = a3_lx_ff;
            end
         endcase
      end
   end

endmodule
